// ===== sv/mfb_pkg.sv =====
// Package for the monochrome framebuffer rectangle fill block.
// Holds geometry constants, request/result structs and the sequencer state type.
// Used by mono_framebuffer_rect_fill and the testbench; depends on nothing.
package mfb_pkg;

  localparam int VERTICAL_ADDRESSES = 32;
  localparam int WORDS_PER_ADDRESS  = 16;
  localparam int WORD_W             = 16;
  localparam int DEPTH              = VERTICAL_ADDRESSES * WORDS_PER_ADDRESS;
  localparam int HALF_WORDS         = WORDS_PER_ADDRESS / 2;
  localparam int ADDR_W             = $clog2(DEPTH);
  localparam int VERT_W             = $clog2(VERTICAL_ADDRESSES);
  localparam int COL_W              = $clog2(HALF_WORDS);
  localparam int PIX_W              = $clog2(WORD_W);
  localparam int COUNT_W            = 10;

  localparam logic CMD_FILL = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [6:0] left_x;
    logic [5:0] top_y;
    logic [6:0] right_x;
    logic [5:0] bottom_y;
    logic       pixel_on;
    logic [4:0] read_vertical;
    logic [3:0] read_horizontal;
  } mfb_req_t;

  typedef struct packed {
    logic [15:0] read_word;
    logic [9:0]  words_touched;
  } mfb_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_DRAIN,
    ST_READ
  } mfb_state_t;

  // Pixel row and word column to store address: row y sits at vertical address
  // y mod VERTICAL_ADDRESSES, lower-half rows in the upper half of the words.
  function automatic logic [ADDR_W-1:0] word_addr(input logic [5:0] y,
                                                  input logic [COL_W-1:0] col);
    logic [VERT_W-1:0] vert;
    logic              half;
    vert = y[VERT_W-1:0];
    half = y[VERT_W];
    return ADDR_W'(vert * WORDS_PER_ADDRESS) + ADDR_W'({half, col});
  endfunction

  // Bits lo..hi counted from the leftmost pixel (bit 15).
  function automatic logic [WORD_W-1:0] edge_mask(input logic [PIX_W-1:0] lo,
                                                  input logic [PIX_W-1:0] hi);
    logic [WORD_W-1:0] ones;
    ones = '1;
    return (ones >> lo) & (ones << (PIX_W'(WORD_W - 1) - hi));
  endfunction

endpackage

// ===== sv/mono_framebuffer_rect_fill.sv =====
// Top level of the monochrome framebuffer rectangle fill block.
// Depends on mfb_pkg and mfb_ram.
//
// A 128x64 one-bit framebuffer held in a 512 x 16 RAM laid out as the panel
// controller's graphics RAM. After reset the block clears the RAM, one word per
// cycle, with busy high. A request is taken when start is high and busy low.
// A fill streams one masked read-modify-write per cycle through the RAM (read
// issued one cycle, write-back the next) over rows * word columns words, then
// reports from ST_DRAIN; a rectangle with reversed corners skips the fill and
// returns a zero count. A read registers the RAM word in ST_READ. Each
// result shows for one cycle with out_valid high and cannot be held off.
module mono_framebuffer_rect_fill (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  mfb_pkg::mfb_req_t in_req,
  output logic             out_valid,
  output mfb_pkg::mfb_res_t out_res
);

  mfb_pkg::mfb_state_t state_r, state_nxt;

  logic [mfb_pkg::ADDR_W-1:0]  clr_r, clr_nxt;
  logic [5:0]                  y_r, y_nxt;
  logic [5:0]                  by_r, by_nxt;
  logic [mfb_pkg::COL_W-1:0]   c_r, c_nxt;
  logic [mfb_pkg::COL_W-1:0]   cbeg_r, cbeg_nxt;
  logic [mfb_pkg::COL_W-1:0]   cend_r, cend_nxt;
  logic [mfb_pkg::PIX_W-1:0]   lpix_r, lpix_nxt;
  logic [mfb_pkg::PIX_W-1:0]   rpix_r, rpix_nxt;
  logic                        on_r, on_nxt;
  logic [mfb_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;

  logic                        wr_pend_r, wr_pend_nxt;
  logic [mfb_pkg::ADDR_W-1:0]  wr_addr_r, wr_addr_nxt;
  logic [mfb_pkg::WORD_W-1:0]  wr_mask_r, wr_mask_nxt;

  logic                        out_valid_r, out_valid_nxt;
  mfb_pkg::mfb_res_t           out_res_r, out_res_nxt;

  logic                        ram_we;
  logic [mfb_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [mfb_pkg::WORD_W-1:0]  ram_wdata, ram_rdata;

  logic                        accept;
  logic                        last_word;
  logic [mfb_pkg::PIX_W-1:0]   lo, hi;

  mfb_ram #(
    .WIDTH(mfb_pkg::WORD_W),
    .DEPTH(mfb_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy      = (state_r != mfb_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign last_word = (y_r == by_r) && (c_r == cend_r);

  // Partial masks only on the rectangle's edge columns.
  assign lo = (c_r == cbeg_r) ? lpix_r : '0;
  assign hi = (c_r == cend_r) ? rpix_r : '1;

  // Write port: clearing sweep, else the pending write-back of a fill.
  always_comb begin
    if (state_r == mfb_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = wr_pend_r;
      ram_waddr = wr_addr_r;
      ram_wdata = on_r ? (ram_rdata | wr_mask_r) : (ram_rdata & ~wr_mask_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    y_nxt         = y_r;
    by_nxt        = by_r;
    c_nxt         = c_r;
    cbeg_nxt      = cbeg_r;
    cend_nxt      = cend_r;
    lpix_nxt      = lpix_r;
    rpix_nxt      = rpix_r;
    on_nxt        = on_r;
    cnt_nxt       = cnt_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    wr_mask_nxt   = wr_mask_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    ram_raddr     = mfb_pkg::word_addr(y_r, c_r);

    case (state_r)
      mfb_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == mfb_pkg::ADDR_W'(mfb_pkg::DEPTH - 1)) begin
          state_nxt = mfb_pkg::ST_IDLE;
        end
      end
      mfb_pkg::ST_IDLE: begin
        ram_raddr = mfb_pkg::ADDR_W'(in_req.read_vertical * mfb_pkg::WORDS_PER_ADDRESS)
                    + mfb_pkg::ADDR_W'(in_req.read_horizontal);
        if (accept) begin
          if (in_req.cmd == mfb_pkg::CMD_READ) begin
            state_nxt = mfb_pkg::ST_READ;
          end else if (in_req.left_x > in_req.right_x || in_req.top_y > in_req.bottom_y) begin
            // reversed corners: nothing to touch
            out_valid_nxt = 1'b1;
            out_res_nxt   = '0;
          end else begin
            y_nxt     = in_req.top_y;
            by_nxt    = in_req.bottom_y;
            c_nxt     = in_req.left_x[6 -: mfb_pkg::COL_W];
            cbeg_nxt  = in_req.left_x[6 -: mfb_pkg::COL_W];
            cend_nxt  = in_req.right_x[6 -: mfb_pkg::COL_W];
            lpix_nxt  = in_req.left_x[mfb_pkg::PIX_W-1:0];
            rpix_nxt  = in_req.right_x[mfb_pkg::PIX_W-1:0];
            on_nxt    = in_req.pixel_on;
            cnt_nxt   = '0;
            state_nxt = mfb_pkg::ST_FILL;
          end
        end
      end
      mfb_pkg::ST_FILL: begin
        // issue the read now, write back next cycle
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = ram_raddr;
        wr_mask_nxt = mfb_pkg::edge_mask(lo, hi);
        cnt_nxt     = cnt_r + 1'b1;
        if (c_r == cend_r) begin
          c_nxt = cbeg_r;
          y_nxt = y_r + 1'b1;
        end else begin
          c_nxt = c_r + 1'b1;
        end
        if (last_word) begin
          state_nxt = mfb_pkg::ST_DRAIN;
        end
      end
      mfb_pkg::ST_DRAIN: begin
        out_valid_nxt             = 1'b1;
        out_res_nxt.read_word     = '0;
        out_res_nxt.words_touched = cnt_r;
        state_nxt                 = mfb_pkg::ST_IDLE;
      end
      mfb_pkg::ST_READ: begin
        out_valid_nxt             = 1'b1;
        out_res_nxt.read_word     = ram_rdata;
        out_res_nxt.words_touched = '0;
        state_nxt                 = mfb_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mfb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfb_pkg::ST_CLEAR;
      clr_r       <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    y_r       <= y_nxt;
    by_r      <= by_nxt;
    c_r       <= c_nxt;
    cbeg_r    <= cbeg_nxt;
    cend_r    <= cend_nxt;
    lpix_r    <= lpix_nxt;
    rpix_r    <= rpix_nxt;
    on_r      <= on_nxt;
    cnt_r     <= cnt_nxt;
    wr_addr_r <= wr_addr_nxt;
    wr_mask_r <= wr_mask_nxt;
    out_res_r <= out_res_nxt;
  end

  a_drain_reports: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mfb_pkg::ST_DRAIN |=> out_valid)
    else $error("fill finished without a result");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> state_r == mfb_pkg::ST_FILL || state_r == mfb_pkg::ST_DRAIN)
    else $error("write-back outstanding while a new request can be taken");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.words_touched <= mfb_pkg::COUNT_W'(mfb_pkg::DEPTH))
    else $error("word count beyond store size");

  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.read_word == '0 || out_res.words_touched == '0)
    else $error("read and fill fields both set");

endmodule

// ===== sv/mfb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
module mfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for mono_framebuffer_rect_fill: issues fill and read requests and checks every
// result against a framebuffer model held in a small scoreboard class.
// Depends on mfb_pkg and the block's RTL only.

module testbench;
  import mfb_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 1150;
  localparam int QUIET_TAIL     = 150;

  class framebuffer_scoreboard;
    logic [WORD_W-1:0] pixel_words [DEPTH];
    mfb_res_t          pending_results [$];
    int                errors;

    function new();
      foreach (pixel_words[i]) pixel_words[i] = '0;
      errors = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t ns: %s", $realtime, msg);
    endfunction

    // Masked read-modify-write over the rectangle; returns the words rewritten.
    function int paint_rect(mfb_req_t r);
      int                count;
      int                base;
      int                lo;
      int                hi;
      int                idx;
      logic [WORD_W-1:0] mask;
      count = 0;
      if (r.left_x > r.right_x || r.top_y > r.bottom_y) return 0;
      for (int y = r.top_y; y <= r.bottom_y; y++) begin
        for (int c = r.left_x >> 4; c <= (r.right_x >> 4); c++) begin
          base = c * 16;
          lo   = (r.left_x > base) ? r.left_x - base : 0;
          hi   = (r.right_x < base + 15) ? r.right_x - base : 15;
          mask = (16'hFFFF >> lo) & (16'hFFFF << (15 - hi));
          idx  = (y % VERTICAL_ADDRESSES) * WORDS_PER_ADDRESS
                 + (y / VERTICAL_ADDRESSES) * HALF_WORDS + c;
          if (r.pixel_on) pixel_words[idx] = pixel_words[idx] | mask;
          else            pixel_words[idx] = pixel_words[idx] & ~mask;
          count++;
        end
      end
      return count;
    endfunction

    function void note_request(mfb_req_t r);
      mfb_res_t exp_res;
      exp_res = '0;
      if (r.cmd == CMD_FILL) begin
        exp_res.words_touched = 10'(paint_rect(r));
      end else begin
        exp_res.read_word =
          pixel_words[r.read_vertical * WORDS_PER_ADDRESS + r.read_horizontal];
      end
      pending_results.push_back(exp_res);
    endfunction

    function void check_result(mfb_res_t got);
      mfb_res_t exp_res;
      if (pending_results.size() == 0) begin
        flag($sformatf("result with no request outstanding: word %h, touched %0d",
                       got.read_word, got.words_touched));
        return;
      end
      exp_res = pending_results.pop_front();
      if (got.read_word !== exp_res.read_word)
        flag($sformatf("read_word mismatch: expected %h, got %h",
                       exp_res.read_word, got.read_word));
      if (got.words_touched !== exp_res.words_touched)
        flag($sformatf("words_touched mismatch: expected %0d, got %0d",
                       exp_res.words_touched, got.words_touched));
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  logic     out_valid;
  mfb_req_t in_req;
  mfb_res_t out_res;
  int       idle_cycles = 0;
  bit       gaps_on;

  framebuffer_scoreboard frame_sb;

  mono_framebuffer_rect_fill dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Check results before noting a request taken at the same edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) frame_sb.check_result(out_res);
    if (rst_n && start && busy === 1'b0) frame_sb.note_request(in_req);
  end

  always @(posedge clk) begin
    if ((rst_n && start && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold the request until the block takes it.
  task automatic issue(input mfb_req_t r);
    in_req <= r;
    start  <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic mfb_req_t random_fields();
    mfb_req_t r;
    r.cmd             = 1'($urandom);
    r.left_x          = 7'($urandom);
    r.top_y           = 6'($urandom);
    r.right_x         = 7'($urandom);
    r.bottom_y        = 6'($urandom);
    r.pixel_on        = 1'($urandom);
    r.read_vertical   = 5'($urandom);
    r.read_horizontal = 4'($urandom);
    return r;
  endfunction

  function automatic mfb_req_t make_fill(int lx, int ty, int rx, int by, bit on);
    mfb_req_t r;
    r          = random_fields();
    r.cmd      = CMD_FILL;
    r.left_x   = 7'(lx);
    r.top_y    = 6'(ty);
    r.right_x  = 7'(rx);
    r.bottom_y = 6'(by);
    r.pixel_on = on;
    return r;
  endfunction

  function automatic mfb_req_t make_read(int v, int h);
    mfb_req_t r;
    r                 = random_fields();
    r.cmd             = CMD_READ;
    r.read_vertical   = 5'(v);
    r.read_horizontal = 4'(h);
    return r;
  endfunction

  function automatic mfb_req_t random_request();
    int pick;
    int lx;
    int rx;
    int ty;
    int by;
    int swap;
    pick = $urandom_range(0, 99);
    if (pick < 40) return make_read($urandom_range(0, 31), $urandom_range(0, 15));
    if (pick < 80) begin
      lx = $urandom_range(0, 127);
      ty = $urandom_range(0, 63);
      rx = lx + $urandom_range(0, 40);
      by = ty + $urandom_range(0, 7);
      if (rx > 127) rx = 127;
      if (by > 63) by = 63;
      return make_fill(lx, ty, rx, by, 1'($urandom));
    end
    if (pick < 90) return make_fill($urandom_range(0, 127), $urandom_range(0, 63),
                                    $urandom_range(0, 127), $urandom_range(0, 63),
                                    1'($urandom));
    if (pick < 97) begin
      lx = $urandom_range(0, 127);
      rx = $urandom_range(0, 127);
      ty = $urandom_range(0, 63);
      by = $urandom_range(0, 63);
      if (lx > rx) begin
        swap = lx; lx = rx; rx = swap;
      end
      if (ty > by) begin
        swap = ty; ty = by; by = swap;
      end
      return make_fill(lx, ty, rx, by, 1'($urandom));
    end
    return make_fill(0, 0, 127, 63, 1'($urandom));
  endfunction

  initial begin
    frame_sb = new();
    start    = 1'b0;
    in_req   = '0;
    rst_n    = 1'b0;
    gaps_on  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: cleared store, full screen, edge masks, half boundary, reversed corners.
    issue(make_read(0, 0));
    issue(make_read(31, 15));
    issue(make_fill(0, 0, 127, 63, 1'b1));
    issue(make_read(17, 9));
    issue(make_fill(1, 1, 126, 62, 1'b0));
    issue(make_read(0, 0));
    pause(3);
    issue(make_read(1, 0));
    issue(make_fill(0, 0, 127, 63, 1'b0));
    issue(make_fill(0, 0, 0, 0, 1'b1));
    issue(make_fill(127, 63, 127, 63, 1'b1));
    issue(make_read(0, 0));
    issue(make_read(31, 15));
    issue(make_fill(3, 31, 12, 32, 1'b1));
    pause(7);
    issue(make_read(31, 0));
    issue(make_read(0, 8));
    issue(make_fill(15, 5, 16, 5, 1'b1));
    issue(make_read(5, 0));
    issue(make_read(5, 1));
    issue(make_fill(100, 10, 99, 20, 1'b1));
    issue(make_fill(10, 40, 20, 39, 1'b1));
    issue(make_fill(127, 63, 0, 0, 1'b0));
    issue(make_fill(0, 63, 127, 63, 1'b0));
    issue(make_read(31, 15));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Stretches of 50 items with or without idling, picked at random; none in the tail.
      if (n % 50 == 0)
        gaps_on = (n < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      issue(random_request());
      if (gaps_on && $urandom_range(0, 99) < 30) pause($urandom_range(1, 18));
    end
    start <= 1'b0;

    do @(posedge clk); while (frame_sb.pending_results.size() != 0);
    repeat (32) @(posedge clk);
    if (frame_sb.errors == 0 && frame_sb.pending_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mfb_pkg.sv
sv/mfb_ram.sv
sv/mono_framebuffer_rect_fill.sv
tb/sv/testbench.sv
